// File: design/gmps_pkg.sv
// Shared constants and controller/datapath handshake types for the grid minimum path sum block.
package gmps_pkg;

   // Width of the grid size register.
   localparam int GRID_SIZE_W = 6;

   // Width and saturation limits of every path sum.
   localparam int TOTAL_W   = 22;
   localparam int TOTAL_MAX = 2097151;
   localparam int TOTAL_MIN = -2097152;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;       // store the accepted cell
      logic pass_init;  // set up the grid pass counters
      logic issue;      // read one cell and its upper sum
      logic walk_init;  // start the walk at the bottom-left corner
      logic walk_rd;    // read the direction bit at the walk position
      logic walk_step;  // record the move and step toward the start
      logic emit;       // load the next result into the output register
   } gmps_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic load_last;   // the load counter sits on the final cell of the grid
      logic issue_last;  // the pass counters sit on the final cell
      logic walk_done;   // the walk has reached the top-right corner
      logic out_free;    // the output register can take a result this cycle
      logic emit_last;   // the next result is the final one of the run
   } gmps_sts_type;

endpackage

// File: design/gmps_req_if.sv
// Input channel carrying one grid cell cost per item.
interface gmps_req_if #(
   parameter int COST_WIDTH = 16
);
   logic                         valid;
   logic                         ready;
   logic signed [COST_WIDTH-1:0] cost;

   modport source (output valid, output cost, input ready);
   modport sink (input valid, input cost, output ready);
endinterface

// File: design/gmps_rsp_if.sv
// Result channel carrying one path move and the minimum sum per item.
interface gmps_rsp_if
   import gmps_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [TOTAL_W-1:0] total;
   logic                      move;
   logic                      has_move;
   logic                      last;

   modport source (output valid, output total, output move, output has_move, output last,
                   input ready);
   modport sink (input valid, input total, input move, input has_move, input last,
                 output ready);
endinterface

// File: design/gmps_ctrl.sv
// Controller state machine that sequences loading, the grid pass, the walk and emission.
module gmps_ctrl
   import gmps_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output gmps_cmd_type cmd,
   input  gmps_sts_type sts
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PASS,
      ST_DRAIN,
      ST_WALK_RD,
      ST_WALK_USE,
      ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      ready_ff;
   logic      ready_in;

   // Next state and the commands issued in the current state.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_LOAD: begin
            cmd.load = req_valid && ready_ff;
            if (req_valid && ready_ff && sts.load_last) begin
               cmd.pass_init = 1'b1;
               state_in      = ST_PASS;
            end
         end
         ST_PASS: begin
            cmd.issue = 1'b1;
            if (sts.issue_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The final cell finishes its sum in this cycle.
            cmd.walk_init = 1'b1;
            state_in      = ST_WALK_RD;
         end
         ST_WALK_RD: begin
            if (sts.walk_done) begin
               state_in = ST_EMIT;
            end else begin
               cmd.walk_rd = 1'b1;
               state_in    = ST_WALK_USE;
            end
         end
         ST_WALK_USE: begin
            cmd.walk_step = 1'b1;
            state_in      = ST_WALK_RD;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.emit_last) begin
                  state_in = ST_LOAD;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign ready_in = (state_in == ST_LOAD);

   // State and the registered ready output.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

// File: design/gmps_datapath.sv
// Datapath with the cell, row sum and direction memories, the walk and the output register.
module gmps_datapath
   import gmps_pkg::*;
#(
   parameter int MAX_SIZE   = 32,
   parameter int COST_WIDTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  gmps_cmd_type                 cmd,
   output gmps_sts_type                 sts,
   input  logic                         csr_wr_en,
   input  logic [GRID_SIZE_W-1:0]       csr_wr_data,
   input  logic signed [COST_WIDTH-1:0] req_cost,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic signed [TOTAL_W-1:0]    rsp_total,
   output logic                         rsp_move,
   output logic                         rsp_has_move,
   output logic                         rsp_last
);

   localparam int SZ_W   = $clog2(MAX_SIZE);
   localparam int CELLS  = MAX_SIZE * MAX_SIZE;
   localparam int CA_W   = $clog2(CELLS);
   localparam int MV_LEN = 2 * (MAX_SIZE - 1);
   localparam int ST_W   = $clog2(MV_LEN + 1);
   localparam int SUM_W  = ((COST_WIDTH > TOTAL_W) ? COST_WIDTH : TOTAL_W) + 1;

   // Memories.
   logic signed [COST_WIDTH-1:0] cell_mem [CELLS];
   logic signed [TOTAL_W-1:0]    rs_mem   [MAX_SIZE];
   logic                         cft_mem  [CELLS];

   // Size registers.
   logic [SZ_W-1:0] n_m1_ff, n_m1_in;
   logic [CA_W-1:0] nn_m1_ff, nn_m1_in;
   logic [SZ_W-1:0] cfg_n_m1;
   logic [CA_W:0]   cfg_n;
   logic [CA_W:0]   cfg_nn;

   // Load, pass and walk counters.
   logic [CA_W-1:0] cnt_ff, cnt_in;
   logic [SZ_W-1:0] row_ff, row_in;
   logic [SZ_W-1:0] col_ff, col_in;
   logic [CA_W-1:0] base_ff, base_in;
   logic [SZ_W-1:0] wr_ff, wr_in;
   logic [SZ_W-1:0] wc_ff, wc_in;
   logic [ST_W-1:0] emit_left_ff, emit_left_in;

   // Compute stage.
   logic                         p_valid_ff;
   logic                         p_row0_ff;
   logic                         p_edge_ff;
   logic [SZ_W-1:0]              p_row_ff;
   logic [SZ_W-1:0]              p_col_ff;
   logic signed [COST_WIDTH-1:0] cost_rd_ff;
   logic signed [TOTAL_W-1:0]    top_rd_ff;
   logic signed [TOTAL_W-1:0]    right_ff;
   logic signed [TOTAL_W-1:0]    total_ff;
   logic signed [TOTAL_W-1:0]    sel_val;
   logic signed [SUM_W-1:0]      sum_wide;
   logic signed [TOTAL_W-1:0]    sum_sat;
   logic                         use_top;
   logic [CA_W-1:0]              issue_addr;
   logic [CA_W-1:0]              cft_wr_addr;
   logic [CA_W-1:0]              walk_addr;

   // Walk and output.
   logic              cft_rd_ff;
   logic [MV_LEN-1:0] mv_ff;
   logic              has_move_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [TOTAL_W-1:0] rsp_total_ff;
   logic              rsp_move_ff;
   logic              rsp_has_move_ff;
   logic              rsp_last_ff;

   // Clamp the written size to 1..MAX_SIZE and precompute the final cell index.
   always_comb begin
      if (csr_wr_data == '0) begin
         cfg_n_m1 = '0;
      end else if (csr_wr_data > GRID_SIZE_W'(MAX_SIZE)) begin
         cfg_n_m1 = SZ_W'(MAX_SIZE - 1);
      end else begin
         cfg_n_m1 = SZ_W'(csr_wr_data - 1'b1);
      end
      cfg_n  = (CA_W + 1)'(cfg_n_m1) + 1'b1;
      cfg_nn = cfg_n * cfg_n;
   end

   assign n_m1_in  = csr_wr_en ? cfg_n_m1 : n_m1_ff;
   assign nn_m1_in = csr_wr_en ? CA_W'(cfg_nn - 1'b1) : nn_m1_ff;

   // Load counter: a size write discards a partly collected grid.
   always_comb begin
      if (csr_wr_en) begin
         cnt_in = '0;
      end else if (cmd.load) begin
         cnt_in = sts.load_last ? '0 : cnt_ff + 1'b1;
      end else begin
         cnt_in = cnt_ff;
      end
   end

   // Pass counters run row by row, each row from the right edge leftward.
   always_comb begin
      row_in  = row_ff;
      col_in  = col_ff;
      base_in = base_ff;
      if (cmd.pass_init) begin
         row_in  = '0;
         col_in  = n_m1_ff;
         base_in = '0;
      end else if (cmd.issue) begin
         if (col_ff == '0) begin
            row_in  = row_ff + 1'b1;
            col_in  = n_m1_ff;
            base_in = base_ff + CA_W'(n_m1_ff) + 1'b1;
         end else begin
            col_in = col_ff - 1'b1;
         end
      end
   end

   assign issue_addr  = base_ff + CA_W'(col_ff);
   assign cft_wr_addr = CA_W'(p_row_ff) * CA_W'(MAX_SIZE) + CA_W'(p_col_ff);
   assign walk_addr   = CA_W'(wr_ff) * CA_W'(MAX_SIZE) + CA_W'(wc_ff);

   // Pick the upper or right neighbor sum; a tie takes the right one.
   always_comb begin
      use_top = !p_row0_ff && (p_edge_ff || (top_rd_ff < right_ff));
      if (p_row0_ff && p_edge_ff) begin
         sel_val = '0;
      end else if (use_top) begin
         sel_val = top_rd_ff;
      end else begin
         sel_val = right_ff;
      end
      sum_wide = SUM_W'(sel_val) + SUM_W'(cost_rd_ff);
      if (sum_wide > SUM_W'(TOTAL_MAX)) begin
         sum_sat = TOTAL_W'(TOTAL_MAX);
      end else if (sum_wide < SUM_W'(TOTAL_MIN)) begin
         sum_sat = TOTAL_W'(TOTAL_MIN);
      end else begin
         sum_sat = TOTAL_W'(sum_wide);
      end
   end

   // Walk position moves up on a down move, otherwise right.
   always_comb begin
      wr_in = wr_ff;
      wc_in = wc_ff;
      if (cmd.walk_init) begin
         wr_in = n_m1_ff;
         wc_in = '0;
      end else if (cmd.walk_step) begin
         if (cft_rd_ff && (wr_ff != '0)) begin
            wr_in = wr_ff - 1'b1;
         end else begin
            wc_in = wc_ff + 1'b1;
         end
      end
   end

   // Number of results still to emit: one for a one-cell grid.
   always_comb begin
      if (cmd.walk_init) begin
         emit_left_in = (n_m1_ff == '0) ? ST_W'(1) : ST_W'({n_m1_ff, 1'b0});
      end else if (cmd.emit) begin
         emit_left_in = emit_left_ff - 1'b1;
      end else begin
         emit_left_in = emit_left_ff;
      end
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         n_m1_ff      <= SZ_W'(MAX_SIZE - 1);
         nn_m1_ff     <= CA_W'(CELLS - 1);
         cnt_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         base_ff      <= '0;
         wr_ff        <= '0;
         wc_ff        <= '0;
         emit_left_ff <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         n_m1_ff      <= n_m1_in;
         nn_m1_ff     <= nn_m1_in;
         cnt_ff       <= cnt_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         base_ff      <= base_in;
         wr_ff        <= wr_in;
         wc_ff        <= wc_in;
         emit_left_ff <= emit_left_in;
         p_valid_ff   <= cmd.issue;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Cell store: written on load, read during the pass.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cell_mem[cnt_ff] <= req_cost;
      end
      if (cmd.issue) begin
         cost_rd_ff <= cell_mem[issue_addr];
      end
   end

   // Row sums: the upper neighbor is read as the cell is issued.
   always_ff @(posedge clock) begin
      if (p_valid_ff) begin
         rs_mem[p_col_ff] <= sum_sat;
      end
      if (cmd.issue) begin
         top_rd_ff <= rs_mem[col_ff];
      end
   end

   // Direction bits: written by the pass, read by the walk.
   always_ff @(posedge clock) begin
      if (p_valid_ff) begin
         cft_mem[cft_wr_addr] <= use_top;
      end
      if (cmd.walk_rd) begin
         cft_rd_ff <= cft_mem[walk_addr];
      end
   end

   // Compute stage tags and running sums.
   always_ff @(posedge clock) begin
      if (cmd.issue) begin
         p_row0_ff <= (row_ff == '0);
         p_edge_ff <= (col_ff == n_m1_ff);
         p_row_ff  <= row_ff;
         p_col_ff  <= col_ff;
      end
      if (p_valid_ff) begin
         right_ff <= sum_sat;
         total_ff <= sum_sat;
      end
   end

   // Moves are pushed in end-to-start order and popped start first.
   always_ff @(posedge clock) begin
      if (cmd.walk_init) begin
         has_move_ff <= (n_m1_ff != '0);
      end
      if (cmd.walk_step) begin
         mv_ff <= {mv_ff[MV_LEN-2:0], cft_rd_ff};
      end else if (cmd.emit) begin
         mv_ff <= mv_ff >> 1;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_total_ff    <= total_ff;
         rsp_move_ff     <= has_move_ff && mv_ff[0];
         rsp_has_move_ff <= has_move_ff;
         rsp_last_ff     <= sts.emit_last;
      end
   end

   // Status toward the controller.
   always_comb begin
      sts.load_last  = (cnt_ff == nn_m1_ff);
      sts.issue_last = (row_ff == n_m1_ff) && (col_ff == '0);
      sts.walk_done  = (wr_ff == '0) && (wc_ff == n_m1_ff);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
      sts.emit_last  = (emit_left_ff == ST_W'(1));
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_total    = rsp_total_ff;
   assign rsp_move     = rsp_move_ff;
   assign rsp_has_move = rsp_has_move_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

// File: design/grid_min_path_sum.sv
// Top level of the grid minimum path sum block.
//
// The req_chan channel takes the cells of an n by n cost grid in row-major order, one
// item per cycle, with n set by the csr_wr_en/csr_wr_data size register (0 acts as 1,
// values above MAX_SIZE act as MAX_SIZE). A size write drops any partly loaded grid.
// After the last cell the block sums the grid row by row, one cell per cycle through
// the cell and row-sum memories, then walks the stored direction bits back from the
// bottom-left corner, each step waiting on a registered read of the direction memory.
// It then sends 2*(n-1) items on rsp_chan, one per cycle while the receiver takes them,
// each with one move from the top-right start and the minimum sum; a one-cell grid
// gives a single item without a move. req_chan.ready is low from the last cell of a
// grid until the final result sits in the output register; loading of the next grid
// may start while it waits there. When the receiver stalls, the output register holds
// its item and the emission waits. Reset sets the size to MAX_SIZE and clears the
// counters and the channel state; the memories are not cleared and are always written
// before use.
module grid_min_path_sum
   import gmps_pkg::*;
#(
   parameter int MAX_SIZE   = 32,
   parameter int COST_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   gmps_req_if.sink               req_chan,
   gmps_rsp_if.source             rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [GRID_SIZE_W-1:0] csr_wr_data
);

   gmps_cmd_type ctrl_cmd;
   gmps_sts_type dp_sts;

   // Sequencer.
   gmps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (ctrl_cmd),
      .sts       (dp_sts)
   );

   // Memories, arithmetic and output register.
   gmps_datapath #(
      .MAX_SIZE   (MAX_SIZE),
      .COST_WIDTH (COST_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (ctrl_cmd),
      .sts          (dp_sts),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_cost     (req_chan.cost),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .rsp_total    (rsp_chan.total),
      .rsp_move     (rsp_chan.move),
      .rsp_has_move (rsp_chan.has_move),
      .rsp_last     (rsp_chan.last)
   );

   // No item is taken while the grid pass is running.
   assert property (@(posedge clock) disable iff (reset) ctrl_cmd.issue |-> !req_chan.ready)
      else $error("input ready during grid pass");

   // A loaded result is offered on the next cycle.
   assert property (@(posedge clock) disable iff (reset) ctrl_cmd.emit |=> rsp_chan.valid)
      else $error("emitted result not offered");

   // A result without a move only comes from a one-cell grid and ends its run.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_chan.valid && !rsp_chan.has_move |-> rsp_chan.last)
      else $error("moveless result not final");

   // The phases never overlap.
   assert property (@(posedge clock) disable iff (reset)
                    $onehot0({ctrl_cmd.load, ctrl_cmd.issue, ctrl_cmd.walk_rd,
                              ctrl_cmd.walk_step, ctrl_cmd.emit}))
      else $error("overlapping datapath commands");

endmodule
